/* hdl/alt_pkg.sv */
package alt_pkg;

    // blank hold buffer sizing
    localparam int BLANK_DEPTH = 16;
    localparam int CNT_W = $clog2(BLANK_DEPTH + 1);
    localparam int IDX_W = (BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1;

    // special characters
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_KEY    = 3'd1,
        PH_VSTART = 3'd2,
        PH_QVAL   = 3'd3,
        PH_UVAL   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ROLE_KEY  = 2'd0,
        ROLE_VAL  = 2'd1,
        ROLE_PAIR = 2'd2,
        ROLE_LIST = 2'd3
    } role_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_BUSY = 1'b1
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic use_new;
        logic emit;
    } alt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic head_any;
        logic rem_any;
        logic out_free;
    } alt_status_t;

endpackage

/* hdl/alt_ctrl.sv */
module alt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  alt_pkg::alt_status_t status,
    output alt_pkg::alt_cmd_t    cmd,
    output logic                in_stall
);
    import alt_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd.accept  = 1'b0;
        cmd.use_new = 1'b0;
        cmd.emit    = 1'b0;
        in_stall    = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.use_new = 1'b1;
                in_stall    = !status.out_free;
                if (in_valid && status.out_free)
                begin
                    cmd.accept = 1'b1;
                    cmd.emit   = status.head_any;
                    if (status.head_any && status.rem_any)
                    begin
                        state_next = ST_BUSY;
                    end
                end
            end
            ST_BUSY:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!status.rem_any)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/alt_datapath.sv */
module alt_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          text_char,
    input  logic                end_of_list,
    input  alt_pkg::alt_cmd_t    cmd,
    output alt_pkg::alt_status_t status,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [1:0]          token_role,
    output logic [7:0]          out_char,
    output logic                blank_overflow,
    output logic                last_of_run
);
    import alt_pkg::*;

    // parse state
    phase_t             phase_reg, phase_next;
    logic               key_reg, key_next;
    logic [CNT_W-1:0]   held_reg, held_next;
    logic               ovf_reg, ovf_next;
    logic               tab_reg [BLANK_DEPTH];

    // pending results of the current byte
    logic [CNT_W-1:0]   fl_left_reg;
    logic [IDX_W-1:0]   fl_idx_reg;
    logic               ch_pend_reg, pair_pend_reg, list_pend_reg;
    role_t              role_reg;
    logic [7:0]         char_reg;
    logic               ovf_run_reg;

    // output register
    logic               out_valid_reg;
    role_t              out_role_reg;
    logic [7:0]         out_char_reg;
    logic               out_ovf_reg;
    logic               out_last_reg;

    // byte decode and plan
    logic               blank;
    logic               do_hold, do_clr, do_flush, do_emit, do_pair, ovf_set;
    role_t              emit_role;
    logic               key_mid;
    phase_t             phase_cur;

    // head selection
    logic [CNT_W-1:0]   src_fl_left;
    logic [IDX_W-1:0]   src_fl_idx;
    logic               src_ch, src_pair, src_list, src_ovf;
    role_t              src_role;
    logic [7:0]         src_char;
    logic [CNT_W-1:0]   rem_fl_left;
    logic [IDX_W-1:0]   rem_fl_idx;
    logic               rem_ch, rem_pair, rem_list;
    role_t              head_role;
    logic [7:0]         head_char;
    logic               held_room;

    assign blank     = (text_char == CH_SPACE) || (text_char == CH_TAB);
    assign held_room = (held_reg < CNT_W'(BLANK_DEPTH));
    assign phase_cur = phase_reg;

    // per-phase parse decision
    always_comb
    begin
        phase_next = phase_cur;
        key_mid    = key_reg;
        do_hold    = 1'b0;
        do_clr     = 1'b0;
        do_flush   = 1'b0;
        do_emit    = 1'b0;
        do_pair    = 1'b0;
        emit_role  = ROLE_KEY;
        unique case (phase_cur)
            PH_KEY:
            begin
                if (blank)
                begin
                    do_hold = 1'b1;
                end
                else if (text_char == CH_EQ)
                begin
                    do_clr     = 1'b1;
                    phase_next = PH_VSTART;
                end
                else if (text_char == CH_COMMA)
                begin
                    do_pair    = key_reg;
                    do_clr     = 1'b1;
                    key_mid    = 1'b0;
                    phase_next = PH_SKIP;
                end
                else
                begin
                    do_flush = 1'b1;
                    do_emit  = 1'b1;
                end
            end
            PH_VSTART:
            begin
                emit_role = ROLE_VAL;
                if (text_char == CH_QUOTE)
                begin
                    phase_next = PH_QVAL;
                end
                else if (text_char == CH_COMMA)
                begin
                    do_pair    = key_reg;
                    do_clr     = 1'b1;
                    key_mid    = 1'b0;
                    phase_next = PH_SKIP;
                end
                else
                begin
                    do_hold    = blank && key_reg;
                    do_emit    = !blank && key_reg;
                    phase_next = PH_UVAL;
                end
            end
            PH_UVAL:
            begin
                emit_role = ROLE_VAL;
                if (text_char == CH_COMMA)
                begin
                    do_pair    = key_reg;
                    do_clr     = 1'b1;
                    key_mid    = 1'b0;
                    phase_next = PH_SKIP;
                end
                else if (blank)
                begin
                    do_hold = key_reg;
                end
                else
                begin
                    do_flush = key_reg;
                    do_emit  = key_reg;
                end
            end
            PH_QVAL:
            begin
                emit_role = ROLE_VAL;
                if (text_char == CH_QUOTE)
                begin
                    do_pair    = key_reg;
                    do_clr     = 1'b1;
                    key_mid    = 1'b0;
                    phase_next = PH_SKIP;
                end
                else
                begin
                    do_emit = key_reg;
                end
            end
            default:
            begin
                // skip phase, unused codes land here too
                phase_next = PH_SKIP;
                if (blank || (text_char == CH_COMMA))
                begin
                    phase_next = PH_SKIP;
                end
                else if (text_char == CH_EQ)
                begin
                    key_mid    = 1'b0;
                    phase_next = PH_VSTART;
                end
                else
                begin
                    key_mid    = 1'b1;
                    do_emit    = 1'b1;
                    phase_next = PH_KEY;
                end
            end
        endcase
        // list end closes an open pair
        if (end_of_list && (phase_next != PH_SKIP))
        begin
            do_pair = key_mid;
        end
    end

    assign ovf_set = do_hold && !held_room;

    // next parse state
    always_comb
    begin
        held_next = held_reg;
        if (do_hold && held_room)
        begin
            held_next = held_reg + CNT_W'(1);
        end
        if (do_clr || do_flush || end_of_list)
        begin
            held_next = '0;
        end
        ovf_next = end_of_list ? 1'b0 : (ovf_reg || ovf_set);
    end

    // source of the next result: new byte or what is pending
    always_comb
    begin
        if (cmd.use_new)
        begin
            src_fl_left = do_flush ? held_reg : '0;
            src_fl_idx  = '0;
            src_ch      = do_emit;
            src_pair    = do_pair;
            src_list    = end_of_list;
            src_role    = emit_role;
            src_char    = text_char;
            src_ovf     = ovf_reg || ovf_set;
        end
        else
        begin
            src_fl_left = fl_left_reg;
            src_fl_idx  = fl_idx_reg;
            src_ch      = ch_pend_reg;
            src_pair    = pair_pend_reg;
            src_list    = list_pend_reg;
            src_role    = role_reg;
            src_char    = char_reg;
            src_ovf     = ovf_run_reg;
        end
    end

    // pick the head result and what remains
    always_comb
    begin
        rem_fl_left = src_fl_left;
        rem_fl_idx  = src_fl_idx;
        rem_ch      = src_ch;
        rem_pair    = src_pair;
        rem_list    = src_list;
        head_role   = ROLE_LIST;
        head_char   = '0;
        priority if (src_fl_left != '0)
        begin
            head_role   = src_role;
            head_char   = tab_reg[src_fl_idx] ? CH_TAB : CH_SPACE;
            rem_fl_left = src_fl_left - CNT_W'(1);
            rem_fl_idx  = src_fl_idx + IDX_W'(1);
        end
        else if (src_ch)
        begin
            head_role = src_role;
            head_char = src_char;
            rem_ch    = 1'b0;
        end
        else if (src_pair)
        begin
            head_role = ROLE_PAIR;
            rem_pair  = 1'b0;
        end
        else
        begin
            head_role = ROLE_LIST;
            rem_list  = 1'b0;
        end
    end

    assign status.head_any = (src_fl_left != '0) || src_ch || src_pair || src_list;
    assign status.rem_any  = (rem_fl_left != '0) || rem_ch || rem_pair || rem_list;
    assign status.out_free = !out_valid_reg || !out_stall;

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            key_reg   <= 1'b0;
            held_reg  <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.accept)
        begin
            phase_reg <= end_of_list ? PH_SKIP : phase_next;
            key_reg   <= end_of_list ? 1'b0 : key_mid;
            held_reg  <= held_next;
            ovf_reg   <= ovf_next;
        end
    end

    // blank hold buffer
    always_ff @(posedge clk)
    begin
        if (cmd.accept && do_hold && held_room)
        begin
            tab_reg[held_reg[IDX_W-1:0]] <= (text_char == CH_TAB);
        end
    end

    // pending results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fl_left_reg   <= '0;
            ch_pend_reg   <= 1'b0;
            pair_pend_reg <= 1'b0;
            list_pend_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            fl_left_reg   <= rem_fl_left;
            ch_pend_reg   <= rem_ch;
            pair_pend_reg <= rem_pair;
            list_pend_reg <= rem_list;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            fl_idx_reg <= rem_fl_idx;
        end
        if (cmd.accept)
        begin
            role_reg    <= src_role;
            char_reg    <= src_char;
            ovf_run_reg <= src_ovf;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_role_reg <= head_role;
            out_char_reg <= head_char;
            out_ovf_reg  <= src_ovf;
            out_last_reg <= !status.rem_any;
        end
    end

    assign out_valid      = out_valid_reg;
    assign token_role     = out_role_reg;
    assign out_char       = out_char_reg;
    assign blank_overflow = out_ovf_reg;
    assign last_of_run    = out_last_reg;

endmodule

/* hdl/attribute_list_tokenizer_core.sv */
// Attribute list tokenizer: takes a KEY=VALUE,... list one byte per transaction
// on the input channel (text_char, end_of_list) and gives tagged tokens on the
// output channel (token_role, out_char, blank_overflow, last_of_run).
// Both channels move a transaction when valid is high and stall is low.
// A byte's first token enters the output register as the byte is taken.
// A byte giving zero or one token leaves the input free: the next byte is taken
// in the following cycle unless the output stalls. A byte giving n tokens (held
// blanks flushed, a character, a pair end, a list end; at most BLANK_DEPTH + 3)
// yields one token per cycle while out_stall is low; in_stall is high meanwhile.
// A stall on the output holds the token in the output register and freezes
// the block; in_stall rises as long as the output register cannot take a token.
// Reset (rst_n low, asynchronous) returns to the skip phase with no held
// blanks, no pending tokens and an empty output register; no clearing pass.
module attribute_list_tokenizer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_char,
    input  logic       end_of_list,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] token_role,
    output logic [7:0] out_char,
    output logic       blank_overflow,
    output logic       last_of_run
);
    import alt_pkg::*;

    alt_cmd_t    cmd;
    alt_status_t status;

    // control sequencer
    alt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // parse state, blank buffer and output register
    alt_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .text_char      (text_char),
        .end_of_list    (end_of_list),
        .cmd            (cmd),
        .status         (status),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .token_role     (token_role),
        .out_char       (out_char),
        .blank_overflow (blank_overflow),
        .last_of_run    (last_of_run)
    );

endmodule

/* tb/attribute_list_tokenizer_core_test.sv */
`timescale 1ns / 100ps

module attribute_list_tokenizer_core_test;

    import alt_pkg::*;

    localparam int RANDOM_BYTES   = 400;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = BLANK_DEPTH + 8;

    // tracks the tokenizer state and keeps the tokens still owed by the block
    class token_scoreboard;
        typedef struct {
            role_t      role;
            logic [7:0] ch;
            logic       ovf;
            logic       last;
        } token_t;

        phase_t           phase;
        bit               key_seen;
        int unsigned      held_n;
        bit               held_tab[BLANK_DEPTH];
        bit               overflow;
        token_t           owed_q[$];
        token_t           run_q[$];
        int               errors;

        function new();
            phase    = PH_SKIP;
            key_seen = 0;
            held_n   = 0;
            overflow = 0;
            errors   = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void add_token(role_t role, logic [7:0] ch);
            token_t t;
            t.role = role;
            t.ch   = ch;
            t.ovf  = overflow;
            t.last = 1'b0;
            run_q.insert(run_q.size(), t);
        endfunction

        // trailing blank goes into the hold buffer, or is dropped when it is full
        function void hold_blank(logic [7:0] ch);
            if (held_n < BLANK_DEPTH) begin
                held_tab[held_n] = (ch == CH_TAB);
                held_n++;
            end
            else begin
                overflow = 1;
            end
        endfunction

        function void flush_blanks(role_t role);
            for (int i = 0; i < held_n; i++)
                add_token(role, held_tab[i] ? CH_TAB : CH_SPACE);
            held_n = 0;
        endfunction

        function void close_pair();
            held_n = 0;
            if (key_seen)
                add_token(ROLE_PAIR, 8'h00);
            key_seen = 0;
        endfunction

        // work out the tokens that one accepted byte causes
        function void note_byte(logic [7:0] ch, logic eol);
            bit blank;
            token_t t;
            blank = (ch == CH_SPACE) || (ch == CH_TAB);
            run_q.delete();
            case (phase)
                PH_KEY:
                begin
                    if (blank) begin
                        hold_blank(ch);
                    end
                    else if (ch == CH_EQ) begin
                        held_n = 0;
                        phase  = PH_VSTART;
                    end
                    else if (ch == CH_COMMA) begin
                        close_pair();
                        phase = PH_SKIP;
                    end
                    else begin
                        flush_blanks(ROLE_KEY);
                        add_token(ROLE_KEY, ch);
                    end
                end
                PH_VSTART:
                begin
                    if (ch == CH_QUOTE) begin
                        phase = PH_QVAL;
                    end
                    else if (ch == CH_COMMA) begin
                        close_pair();
                        phase = PH_SKIP;
                    end
                    else begin
                        if (blank) begin
                            if (key_seen)
                                hold_blank(ch);
                        end
                        else if (key_seen) begin
                            add_token(ROLE_VAL, ch);
                        end
                        phase = PH_UVAL;
                    end
                end
                PH_UVAL:
                begin
                    if (ch == CH_COMMA) begin
                        close_pair();
                        phase = PH_SKIP;
                    end
                    else if (blank) begin
                        if (key_seen)
                            hold_blank(ch);
                    end
                    else if (key_seen) begin
                        flush_blanks(ROLE_VAL);
                        add_token(ROLE_VAL, ch);
                    end
                end
                PH_QVAL:
                begin
                    if (ch == CH_QUOTE) begin
                        close_pair();
                        phase = PH_SKIP;
                    end
                    else if (key_seen) begin
                        add_token(ROLE_VAL, ch);
                    end
                end
                default:
                begin
                    if (blank || ch == CH_COMMA) begin
                        phase = PH_SKIP;
                    end
                    else if (ch == CH_EQ) begin
                        key_seen = 0;
                        phase    = PH_VSTART;
                    end
                    else begin
                        key_seen = 1;
                        add_token(ROLE_KEY, ch);
                        phase = PH_KEY;
                    end
                end
            endcase

            // list end closes any open pair
            if (eol) begin
                if (phase != PH_SKIP)
                    close_pair();
                held_n = 0;
                add_token(ROLE_LIST, 8'h00);
                phase    = PH_SKIP;
                key_seen = 0;
                overflow = 0;
            end

            if (run_q.size() > 0)
                run_q[run_q.size() - 1].last = 1'b1;
            foreach (run_q[i]) begin
                t = run_q[i];
                owed_q.insert(owed_q.size(), t);
            end
        endfunction

        // compare one accepted token with the oldest owed one
        function void check_token(logic [1:0] role, logic [7:0] ch, logic ovf, logic last);
            token_t t;
            if (owed_q.size() == 0) begin
                $error("unexpected token: token_role %0d out_char %02h", role, ch);
                errors++;
                return;
            end
            t = owed_q.pop_front();
            if (role !== t.role) begin
                $error("token_role: expected %0d, actual %0d", t.role, role);
                errors++;
            end
            if (ch !== t.ch) begin
                $error("out_char: expected %02h, actual %02h", t.ch, ch);
                errors++;
            end
            if (ovf !== t.ovf) begin
                $error("blank_overflow: expected %0b, actual %0b", t.ovf, ovf);
                errors++;
            end
            if (last !== t.last) begin
                $error("last_of_run: expected %0b, actual %0b", t.last, last);
                errors++;
            end
        endfunction
    endclass

    typedef enum int {RX_FREE, RX_RANDOM, RX_LONG, RX_TOGGLE} rx_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] text_char = 8'h00;
    logic       end_of_list = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] token_role;
    logic [7:0] out_char;
    logic       blank_overflow;
    logic       last_of_run;

    token_scoreboard sb;
    logic [7:0]      list_buf[$];
    int              burst_left = 0;
    int              random_sent = 0;
    int              idle_cycles = 0;
    rx_mode_t        rx_mode = RX_FREE;
    int              rx_mode_left = 0;
    int              rx_run_left = 0;
    bit              rx_hold = 0;

    attribute_list_tokenizer_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .text_char      (text_char),
        .end_of_list    (end_of_list),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .token_role     (token_role),
        .out_char       (out_char),
        .blank_overflow (blank_overflow),
        .last_of_run    (last_of_run)
    );

    // 10 ns clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver stall pattern, switching between modes now and then
    always @(negedge clk)
    begin
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 150);
        end
        rx_mode_left--;
        case (rx_mode)
            RX_FREE:   out_stall <= 1'b0;
            RX_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
            RX_LONG:
            begin
                if (rx_run_left == 0) begin
                    rx_hold     = !rx_hold;
                    rx_run_left = rx_hold ? $urandom_range(1, 8) : $urandom_range(1, 4);
                end
                rx_run_left--;
                out_stall <= rx_hold;
            end
            default:   out_stall <= !out_stall;
        endcase
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_token(token_role, out_char, blank_overflow, last_of_run);
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("attribute_list_tokenizer_core_test: FAIL");
                $finish;
            end
        end
    end

    // append one byte to the list being built
    function automatic void add_byte(logic [7:0] b);
        list_buf.insert(list_buf.size(), b);
    endfunction

    function automatic logic [7:0] blank_char();
        return ($urandom_range(0, 1) == 0) ? CH_TAB : CH_SPACE;
    endfunction

    // any byte that has no special meaning to the tokenizer
    function automatic logic [7:0] plain_char();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(0, 255));
        while (ch == CH_EQ || ch == CH_COMMA || ch == CH_QUOTE ||
               ch == CH_SPACE || ch == CH_TAB);
        return ch;
    endfunction

    task automatic add_blanks(int n);
        repeat (n) add_byte(blank_char());
    endtask

    // sender gap with valid low
    task automatic sender_gap(int n);
        if (n > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // one input transaction, bursts with random gaps between them
    task automatic send_byte(logic [7:0] ch, logic eol);
        if (burst_left == 0) begin
            sender_gap($urandom_range(0, 6));
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        in_valid    <= 1'b1;
        text_char   <= ch;
        end_of_list <= eol;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(ch, eol);
    endtask

    task automatic send_buffer();
        foreach (list_buf[i])
            send_byte(list_buf[i], i == list_buf.size() - 1);
    endtask

    task automatic send_text(string s);
        list_buf.delete();
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
        send_buffer();
    endtask

    // hold the sender until every owed token has come out
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        burst_left = 0;
    endtask

    // mostly well-formed lists with random content, some noise and truncation
    task automatic send_random_list();
        int npairs;
        int klen;
        int vlen;
        int kind;
        list_buf.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
        end
        else begin
            npairs = $urandom_range(1, 4);
            for (int p = 0; p < npairs; p++) begin
                if ($urandom_range(0, 3) == 0)
                    add_blanks($urandom_range(1, 3));
                klen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
                for (int k = 0; k < klen; k++) begin
                    add_byte(plain_char());
                    if ($urandom_range(0, 4) == 0)
                        add_blanks($urandom_range(1, 2));
                end
                kind = $urandom_range(0, 9);
                if (kind != 0) begin
                    add_byte(CH_EQ);
                    if (kind <= 3) begin
                        // quoted value, may stay open
                        add_byte(CH_QUOTE);
                        vlen = $urandom_range(0, 5);
                        repeat (vlen) begin
                            case ($urandom_range(0, 5))
                                0:       add_byte(CH_COMMA);
                                1:       add_byte(CH_EQ);
                                2:       add_byte(blank_char());
                                default: add_byte(plain_char());
                            endcase
                        end
                        if ($urandom_range(0, 5) != 0)
                            add_byte(CH_QUOTE);
                    end
                    else begin
                        if ($urandom_range(0, 2) == 0)
                            add_blanks($urandom_range(1, 2));
                        vlen = $urandom_range(0, 5);
                        repeat (vlen) begin
                            if ($urandom_range(0, 3) == 0)
                                add_blanks($urandom_range(1, 2));
                            else
                                add_byte(plain_char());
                        end
                        // long blank run to fill the hold buffer
                        if ($urandom_range(0, 7) == 0) begin
                            add_blanks($urandom_range(BLANK_DEPTH - 2, BLANK_DEPTH + 4));
                            if ($urandom_range(0, 2) != 0)
                                add_byte(plain_char());
                        end
                    end
                end
                if (p < npairs - 1 || $urandom_range(0, 4) == 0) begin
                    if (list_buf.size() == 0 ||
                        list_buf[list_buf.size() - 1] != CH_QUOTE ||
                        $urandom_range(0, 2) != 0)
                        add_byte(CH_COMMA);
                end
            end
            if (list_buf.size() > 1 && $urandom_range(0, 5) == 0)
                list_buf = list_buf[0:$urandom_range(0, list_buf.size() - 1)];
        end
        random_sent += list_buf.size();
        send_buffer();
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // leading blanks, held key blanks, leading value blanks, empty key by '='
        send_text("\tk =\tv ,=z");
        // quoted comma and tab, key right after a closing quote, list end after '='
        send_text("a=\"x,\ty\"b=");
        // byte extremes and a quote left open at the list end
        list_buf.delete();
        add_byte(8'h00);
        add_byte(CH_EQ);
        add_byte(CH_QUOTE);
        add_byte(8'hFF);
        send_buffer();
        wait_for_drain();

        while (random_sent < RANDOM_BYTES) begin
            send_random_list();
            if ($urandom_range(0, 11) == 0)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("attribute_list_tokenizer_core_test: PASS");
        else
            $display("attribute_list_tokenizer_core_test: FAIL");
        $finish;
    end

endmodule

/* sim.f */
hdl/alt_pkg.sv
hdl/alt_ctrl.sv
hdl/alt_datapath.sv
hdl/attribute_list_tokenizer_core.sv
tb/attribute_list_tokenizer_core_test.sv
